// ===== rtl/core/permutation_generator_adjacent_swap_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the adjacent-swap permutation generator
// Shorthand for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_GENERATOR_ADJACENT_SWAP_DEFINES_SVH
`define PERMUTATION_GENERATOR_ADJACENT_SWAP_DEFINES_SVH

// Same-cycle implication: when the antecedent holds, the consequent holds too.
`define PGAS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pgas check failed");

// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define PGAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pgas check failed");

`endif

// ===== rtl/core/pgas_pkg.sv =====
// ----------------------------------------------------------------------------
// pgas_pkg
// Shared constants and types of the adjacent-swap permutation generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgas_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int VAL_W        = 4;
    localparam int BEST_W       = VAL_W + 1;
    localparam int COUNT_W      = 5;
    localparam int SCAN_W       = $clog2(MAX_ELEMENTS);
    localparam int PERM_W       = MAX_ELEMENTS * VAL_W;

    // Contents of one cell: the value (minus one) and its direction.
    typedef struct packed {
        logic             dir;     // 1 = points right
        logic [VAL_W-1:0] value;
    } t_cell_state;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             load;    // reload identity, directions left
        logic             apply;   // perform the swap and flips for pivot
        logic [VAL_W-1:0] pivot;   // value of the largest mobile element
    } t_cell_ctrl;

endpackage

// ===== rtl/core/pgas_cell.sv =====
// ----------------------------------------------------------------------------
// pgas_cell
// One position of the row: value, direction, mobility and a stage of the
// registered maximum chain that finds the largest mobile value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgas_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pgas_pkg::t_cell_ctrl         i_ctrl,
    input  logic [pgas_pkg::VAL_W-1:0]   i_ident,
    input  logic                         i_active,
    input  logic                         i_left_ok,
    input  logic                         i_right_ok,
    input  pgas_pkg::t_cell_state        i_left,
    input  pgas_pkg::t_cell_state        i_right,
    input  logic [pgas_pkg::BEST_W-1:0]  i_best,
    output pgas_pkg::t_cell_state        o_state,
    output logic [pgas_pkg::BEST_W-1:0]  o_best
);
    import pgas_pkg::*;

    t_cell_state         r_state;
    t_cell_state         n_state;
    t_cell_state         w_moved;
    logic [BEST_W-1:0]   r_best;
    logic [BEST_W-1:0]   n_best;
    logic [BEST_W-1:0]   w_cand;
    logic                w_mobile;

    // A value is mobile when the neighbor it points at is inside the row and smaller.
    assign w_mobile = i_active && (r_state.dir ? (i_right_ok && r_state.value > i_right.value)
                                               : (i_left_ok && r_state.value > i_left.value));
    assign w_cand   = w_mobile ? {1'b1, r_state.value} : '0;
    assign n_best   = (w_cand > i_best) ? w_cand : i_best;

    always_comb begin
        w_moved = r_state;
        if (i_active && r_state.value == i_ctrl.pivot) begin
            w_moved = r_state.dir ? i_right : i_left;
        end else if (i_left_ok && i_left.dir && i_left.value == i_ctrl.pivot) begin
            w_moved = i_left;
        end else if (i_right_ok && !i_right.dir && i_right.value == i_ctrl.pivot) begin
            w_moved = i_right;
        end
        n_state = r_state;
        if (i_ctrl.load) begin
            n_state.value = i_ident;
            n_state.dir   = 1'b0;
        end else if (i_ctrl.apply) begin
            n_state = w_moved;
            if (i_active && w_moved.value > i_ctrl.pivot) begin
                n_state.dir = ~w_moved.dir;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.value <= i_ident;
            r_state.dir   <= 1'b0;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
    end

    assign o_state = r_state;
    assign o_best  = r_best;

endmodule

// ===== rtl/core/permutation_generator_adjacent_swap.sv =====
// ----------------------------------------------------------------------------
// permutation_generator_adjacent_swap
// Johnson-Trotter permutation source built from a row of sixteen cells.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake                   Payload
//  s_axis   in   s_axis_tvalid/tready        tdata[0] = restart
//  m_axis   out  m_axis_tvalid/tready        tdata = permutation, tlast = is_last,
//                                            tuser = exhausted
//  cfg      in   i_cfg_we (no back-pressure) i_cfg_wdata = element_count
//
//  An accepted permutation item first waits in the scan state while the largest
//  mobile value ripples through a registered maximum chain one cell per cycle;
//  the apply state then performs the swap and registers the result. An item after the
//  end of the sequence is answered in the cycle after acceptance with exhausted set.
//  Synchronous active-low reset loads the identity, all left, and a count of four.
//  A stalled result holds in the output register and blocks new items.
//
`timescale 1ns / 1ps

`include "permutation_generator_adjacent_swap_defines.svh"

module permutation_generator_adjacent_swap (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration: element_count, written whenever i_cfg_we is high.
    input  logic                          i_cfg_we,
    input  logic [pgas_pkg::COUNT_W-1:0]  i_cfg_wdata,
    // Input items.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,    // [0] restart, [7:1] zero
    // Result items.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pgas_pkg::PERM_W-1:0]   m_axis_tdata,    // [63:0] permutation
    output logic                          m_axis_tlast,    // is_last
    output logic                          m_axis_tuser     // [0] exhausted
);
    import pgas_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    t_state               r_state;
    logic [SCAN_W-1:0]    r_cnt;
    logic                 r_done;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_o_valid;
    logic [PERM_W-1:0]    r_o_perm;
    logic                 r_o_last;
    logic                 r_o_exh;

    logic                 w_accept;
    logic                 w_restart;
    logic                 w_found;
    logic [COUNT_W-1:0]   w_n;
    logic [PERM_W-1:0]    w_perm;
    logic [BEST_W-1:0]    w_top_best;
    t_cell_ctrl           w_ctrl;

    t_cell_state          w_state [MAX_ELEMENTS];
    logic [BEST_W-1:0]    w_best  [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] w_active;
    logic [MAX_ELEMENTS-1:0] w_right_ok;

    // A count of zero acts as one element, a count above the row as the whole row.
    always_comb begin
        if (r_count == '0) begin
            w_n = COUNT_W'(1);
        end else if (r_count > COUNT_W'(MAX_ELEMENTS)) begin
            w_n = COUNT_W'(MAX_ELEMENTS);
        end else begin
            w_n = r_count;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && (!r_o_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_restart     = s_axis_tdata[0];

    // The last cell of the chain holds {found, value} of the largest mobile element.
    assign w_top_best = w_best[MAX_ELEMENTS-1];
    assign w_found    = w_top_best[BEST_W-1];

    assign w_ctrl.load  = w_accept && w_restart;
    assign w_ctrl.apply = (r_state == S_APPLY) && w_found;
    assign w_ctrl.pivot = w_top_best[VAL_W-1:0];

    // The row of cells. Each cell sees its direct neighbors and passes the
    // running maximum of mobile values to the cell on its right every cycle.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
            t_cell_state       w_left;
            t_cell_state       w_right;
            logic [BEST_W-1:0] w_best_in;

            assign w_active[gi]   = COUNT_W'(gi) < w_n;
            assign w_right_ok[gi] = COUNT_W'(gi + 1) < w_n;

            if (gi == 0) begin : g_first
                assign w_left    = '0;
                assign w_best_in = '0;
            end else begin : g_inner
                assign w_left    = w_state[gi-1];
                assign w_best_in = w_best[gi-1];
            end

            if (gi == MAX_ELEMENTS - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_notlast
                assign w_right = w_state[gi+1];
            end

            pgas_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl),
                .i_ident    (VAL_W'(gi)),
                .i_active   (w_active[gi]),
                .i_left_ok  (gi != 0),
                .i_right_ok (w_right_ok[gi]),
                .i_left     (w_left),
                .i_right    (w_right),
                .i_best     (w_best_in),
                .o_state    (w_state[gi]),
                .o_best     (w_best[gi])
            );

            // Positions outside the active row read as zero.
            assign w_perm[gi*VAL_W +: VAL_W] = w_active[gi] ? w_state[gi].value : '0;
        end
    endgenerate

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_W'(4);
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_done    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_restart) begin
                            r_done <= 1'b0;
                        end
                        if (!w_restart && r_done) begin
                            // Sequence already ended: report exhaustion at once.
                            r_o_valid <= 1'b1;
                            r_o_perm  <= '0;
                            r_o_last  <= 1'b0;
                            r_o_exh   <= 1'b1;
                        end else begin
                            r_cnt   <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Wait until the maximum has rippled through every cell.
                    r_cnt <= r_cnt + SCAN_W'(1);
                    if (r_cnt == SCAN_W'(MAX_ELEMENTS - 1)) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    // Emit the row as it stands; the cells advance in the same edge.
                    r_o_valid <= 1'b1;
                    r_o_perm  <= w_perm;
                    r_o_last  <= !w_found;
                    r_o_exh   <= 1'b0;
                    if (!w_found) begin
                        r_done <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_perm;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_exh;

    // While an item is in the row, the output register must be empty.
    `PGAS_ASSERT_NOW(a_busy_out_empty, r_state != S_IDLE, !r_o_valid)
    // An exhaustion report carries a zero permutation and is never marked last.
    `PGAS_ASSERT_NOW(a_exh_clean, r_o_valid && r_o_exh, r_o_perm == '0 && !r_o_last)
    // An accepted item with a live sequence starts a fresh scan.
    `PGAS_ASSERT_NEXT(a_scan_start, w_accept && (w_restart || !r_done),
                      r_state == S_SCAN && r_cnt == '0)
    // A step that found a mobile element keeps the sequence alive.
    `PGAS_ASSERT_NEXT(a_found_alive, r_state == S_APPLY && w_found,
                      !r_done && r_o_valid && !r_o_last)

endmodule

// ===== verif/permutation_generator_adjacent_swap_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_generator_adjacent_swap_tb
// Self-checking bench for the Johnson-Trotter permutation source. A local
// copy of the row (values and directions) predicts every permutation,
// last flag and exhaustion flag. Directed runs cover the count extremes and
// corner cases, then random sequences, mostly complete, run under random stalls.
// ----------------------------------------------------------------------------

module permutation_generator_adjacent_swap_tb;

    import pgas_pkg::*;

    // Values of the restart bit of an input item.
    localparam bit RESTART  = 1'b1;
    localparam bit CONTINUE = 1'b0;

    localparam int RANDOM_ITEMS   = 600;
    localparam int CALM_AFTER     = 520;   // no idling on either side past this
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
    localparam int SETTLE_CYCLES  = 30;    // covers the result latency

    // One result item, field for field.
    typedef struct packed {
        logic [PERM_W-1:0] permutation;
        logic              is_last;
        logic              exhausted;
    } t_perm_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [COUNT_W-1:0]   i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;    // [0] restart, [7:1] zero
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [PERM_W-1:0]    m_axis_tdata;         // [63:0] permutation
    logic                 m_axis_tlast;         // is_last
    logic                 m_axis_tuser;         // [0] exhausted

    permutation_generator_adjacent_swap uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the row and of the element count.
    // ------------------------------------------------------------------------
    logic [VAL_W-1:0]   row_val   [MAX_ELEMENTS];
    logic               row_right [MAX_ELEMENTS];
    logic               row_done;
    logic [COUNT_W-1:0] elem_count;

    t_perm_result expected_perms[$];

    int  mismatches   = 0;
    int  items_sent   = 0;
    bit  calm         = 1'b0;
    int  src_idle_pct = 0;
    int  sink_stall_pct = 0;
    int  stall_left   = 0;
    int  quiet_cycles = 0;

    // Identity row, all values pointing left, sequence not finished.
    function automatic void load_identity_row();
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            row_val[i]   = VAL_W'(i);
            row_right[i] = 1'b0;
        end
        row_done = 1'b0;
    endfunction

    // Count actually used by the block: zero acts as one, over-range as the max.
    function automatic int active_elements(input logic [COUNT_W-1:0] cnt);
        if (cnt == 0) return 1;
        if (cnt > MAX_ELEMENTS) return MAX_ELEMENTS;
        return int'(cnt);
    endfunction

    // One Johnson-Trotter step: record the permutation that is emitted and
    // move the largest mobile value one place in its direction.
    function automatic void predict_next_perm(input bit restart);
        t_perm_result     r;
        int               n;
        int               best;
        int               adj;
        int               dst;
        logic [VAL_W-1:0] tv;
        logic             td;
        n = active_elements(elem_count);
        r = '0;
        if (restart) load_identity_row();
        if (row_done) begin
            // Past the end: only the exhaustion flag, the row is left alone.
            r.exhausted = 1'b1;
        end else begin
            for (int i = 0; i < n; i++) r.permutation[VAL_W*i +: VAL_W] = row_val[i];
            // A value is mobile when the neighbor it points at (within the
            // first n positions) is smaller; ties cannot occur in a real row.
            best = -1;
            for (int i = 0; i < n; i++) begin
                adj = row_right[i] ? i + 1 : i - 1;
                if (adj >= 0 && adj < n && row_val[i] > row_val[adj] &&
                    (best < 0 || row_val[i] > row_val[best]))
                    best = i;
            end
            if (best < 0) begin
                r.is_last = 1'b1;
                row_done  = 1'b1;
            end else begin
                dst = row_right[best] ? best + 1 : best - 1;
                tv  = row_val[best];
                td  = row_right[best];
                row_val[best]   = row_val[dst];
                row_right[best] = row_right[dst];
                row_val[dst]    = tv;
                row_right[dst]  = td;
                // Every larger value reverses direction.
                for (int i = 0; i < n; i++)
                    if (row_val[i] > tv) row_right[i] = ~row_right[i];
            end
        end
        expected_perms.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Sender side. The valid stays high from one item to the next when there
    // is no gap, so it is never lowered and raised in one time step.
    // ------------------------------------------------------------------------
    task automatic send_request(input bit restart);
        int gap;
        if (!calm && $urandom_range(99) < src_idle_pct) begin
            gap = $urandom_range(11, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_next_perm(restart);
        items_sent++;
    endtask

    // Hold the sender until every predicted result has come back. The wait
    // steps the clock before it checks, so the valid is never lowered and raised in one step.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_perms.size() != 0);
    endtask

    // The count register is only touched while the block is idle.
    task automatic set_element_count(input logic [COUNT_W-1:0] value);
        wait_results_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        elem_count  = value;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stall bursts, none when calm.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (calm) begin
            m_axis_tready <= 1'b1;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else if ($urandom_range(99) < sink_stall_pct) begin
            stall_left    <= $urandom_range(11, 1);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Every accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_perm_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_perms.size() == 0) begin
                $display("%0t: result with nothing predicted: perm=%h last=%b exhausted=%b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                mismatches++;
            end else begin
                want = expected_perms.pop_front();
                if (m_axis_tdata !== want.permutation) begin
                    $display("%0t: permutation expected %h actual %h",
                             $time, want.permutation, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.is_last) begin
                    $display("%0t: is_last expected %b actual %b",
                             $time, want.is_last, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser !== want.exhausted) begin
                    $display("%0t: exhausted expected %b actual %b",
                             $time, want.exhausted, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    // A hung handshake on either side ends the run.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("permutation_generator_adjacent_swap: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Straight out of reset the count is four and the row is the identity.
    task automatic test_reset_state();
        repeat (3) send_request(CONTINUE);
    endtask

    // One element: the identity is also the last permutation, then exhaustion.
    task automatic test_single_element();
        set_element_count(COUNT_W'(1));
        send_request(RESTART);
        repeat (2) send_request(CONTINUE);
    endtask

    // A count of zero behaves like one.
    task automatic test_count_zero();
        set_element_count(COUNT_W'(0));
        send_request(RESTART);
        send_request(CONTINUE);
    endtask

    // All count bits set is beyond the row and clamps to sixteen.
    task automatic test_count_overflow();
        set_element_count(5'd31);
        send_request(RESTART);
        repeat (3) send_request(CONTINUE);
    endtask

    // Two elements finish after two permutations; restart after exhaustion.
    task automatic test_pair_sequence();
        set_element_count(COUNT_W'(2));
        send_request(RESTART);
        repeat (2) send_request(CONTINUE);
        send_request(RESTART);
    endtask

    // Growing the count without restart keeps the row and works on more of it.
    task automatic test_count_change_midway();
        set_element_count(COUNT_W'(3));
        send_request(RESTART);
        send_request(CONTINUE);
        set_element_count(COUNT_W'(5));
        repeat (2) send_request(CONTINUE);
    endtask

    // ------------------------------------------------------------------------
    // Random part: mostly complete sequences of small sizes run to exhaustion,
    // some partial runs at large or out-of-range counts, with stray restarts,
    // mid-run count changes and drain pauses mixed in.
    // ------------------------------------------------------------------------
    task automatic test_random_sequences();
        int                 start_items;
        int                 pick;
        int                 n;
        int                 run_len;
        int                 break_at;
        logic [COUNT_W-1:0] cnt;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            if (items_sent - start_items >= CALM_AFTER) calm = 1'b1;
            pick = $urandom_range(99);
            if (pick < 10)      cnt = COUNT_W'($urandom_range(31, 6));
            else if (pick < 14) cnt = '0;
            else                cnt = COUNT_W'($urandom_range(5, 1));
            src_idle_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
            sink_stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
            set_element_count(cnt);
            n = active_elements(cnt);
            // Small rows run through all n! permutations plus a few past the end.
            if (n <= 5) begin
                run_len = 1;
                for (int i = 2; i <= n; i++) run_len *= i;
                run_len += $urandom_range(3);
            end else begin
                run_len = $urandom_range(20, 3);
            end
            break_at = ($urandom_range(7) == 0) ? $urandom_range(run_len - 1, 1) : -1;
            send_request(RESTART);
            for (int k = 1; k < run_len; k++) begin
                if (k == break_at) set_element_count(COUNT_W'($urandom_range(6, 1)));
                if ($urandom_range(99) < 2) wait_results_drained();
                send_request(($urandom_range(99) < 3) ? RESTART : CONTINUE);
            end
        end
    endtask

    initial begin
        elem_count = 5'd4;
        load_identity_row();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct   = 20;
        sink_stall_pct = 20;
        test_reset_state();
        test_single_element();
        test_count_zero();
        test_count_overflow();
        test_pair_sequence();
        test_count_change_midway();
        test_random_sequences();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_perms.size() == 0)
            $display("permutation_generator_adjacent_swap: match");
        else
            $display("permutation_generator_adjacent_swap: mismatch");
        $finish;
    end

endmodule
